// ===== hw/rtl/lts_pkg.sv =====
// Shared types and codes for the landing touchdown sequencer.
package lts_pkg;

  localparam int IN_W    = 146;
  localparam int IN_TDW  = 152;
  localparam int OUT_W   = 73;
  localparam int OUT_TDW = 80;
  localparam int ADDR_W  = 5;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_INIT    = 3'd1,
    PH_DESCEND = 3'd2,
    PH_DISARM  = 3'd3,
    PH_DONE    = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    ST_RUNNING = 2'd0,
    ST_SUCCESS = 2'd1,
    ST_NONE    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    MODE_NONE      = 2'd0,
    MODE_HEARTBEAT = 2'd1,
    MODE_RAW       = 2'd2
  } mode_t;

  localparam logic [1:0] FUNC_START = 2'd0;
  localparam logic [1:0] FUNC_TICK  = 2'd1;
  localparam logic [1:0] FUNC_HALT  = 2'd2;

  localparam logic [2:0] REG_DESCENT_RATE = 3'd0;
  localparam logic [2:0] REG_TOTAL_TMO    = 3'd1;
  localparam logic [2:0] REG_GROUND_HOLD  = 3'd2;
  localparam logic [2:0] REG_HEIGHT_TOL   = 3'd3;
  localparam logic [2:0] REG_SPEED_TOL    = 3'd4;
  localparam logic [2:0] REG_RETRY_PERIOD = 3'd5;

  typedef struct packed {
    logic signed [15:0] descent_rate;
    logic [31:0]        total_timeout;
    logic [31:0]        ground_hold_time;
    logic [22:0]        height_tolerance;
    logic [14:0]        speed_tolerance;
    logic [31:0]        retry_period;
  } cfg_t;

  // Declared high field first: time_ms ends up in the lowest bits.
  typedef struct packed {
    logic signed [23:0] home_height;
    logic signed [15:0] vert_speed;
    logic signed [23:0] pos_z;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_x;
    logic               landed_flag;
    logic               armed;
    logic [31:0]        time_ms;
  } in_item_t;

  typedef struct packed {
    phase_t             phase_now;
    logic signed [15:0] target_vz;
    logic signed [23:0] target_y;
    logic signed [23:0] target_x;
    logic               target_write;
    logic               disarm_request;
    mode_t              mode_command;
    status_t            status;
  } out_item_t;

endpackage

// ===== hw/rtl/landing_touchdown_sequencer.sv =====
// Top level: request stream in, one result per request out, APB configuration.
// An accepted request is held in the input register, then its result in the output register.
// Throughput: one request per cycle unless the output stalls (m_tready low); input and
// output registers decouple the two streams, and the combinational step between them sets the rate.
// Reset (rst, synchronous): both stages empty, phase idle, stamps and
// home height zero, registers at their default values.
module landing_touchdown_sequencer (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // time_ms[31:0], armed[32], landed_flag[33], pos_x[57:34], pos_y[81:58],
  // pos_z[105:82], vert_speed[121:106], home_height[145:122], zero pad
  input  logic [lts_pkg::IN_TDW-1:0]  s_tdata,
  // func[1:0]
  input  logic [1:0]                  s_tuser,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // status[1:0], mode_command[3:2], disarm_request[4], target_write[5],
  // target_x[29:6], target_y[53:30], target_vz[69:54], phase_now[72:70], zero pad
  output logic [lts_pkg::OUT_TDW-1:0] m_tdata,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lts_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  lts_pkg::cfg_t      cfg;
  lts_pkg::in_item_t  in_item;
  lts_pkg::out_item_t step_out, out_item;
  logic [1:0]         in_func;
  logic               in_valid, out_valid, advance;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;
  assign m_tvalid = out_valid;
  assign m_tdata  = {{(lts_pkg::OUT_TDW - lts_pkg::OUT_W){1'b0}}, out_item};

  lts_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lts_step u_step (
    .clk    (clk),
    .rst    (rst),
    .en     (advance),
    .func   (in_func),
    .item   (in_item),
    .cfg    (cfg),
    .result (step_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (!out_valid || m_tready) begin
        out_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item <= s_tdata[lts_pkg::IN_W-1:0];
      in_func <= s_tuser;
    end
    if (advance) begin
      out_item <= step_out;
    end
  end

endmodule

// ===== hw/rtl/lts_regs.sv =====
// Configuration register file behind the APB port.
module lts_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lts_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output lts_pkg::cfg_t              cfg
);

  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.descent_rate     <= -16'sd500;
      cfg.total_timeout    <= 32'd60000;
      cfg.ground_hold_time <= 32'd3000;
      cfg.height_tolerance <= 23'd300;
      cfg.speed_tolerance  <= 15'd200;
      cfg.retry_period     <= 32'd2000;
    end else if (wr) begin
      case (idx)
        lts_pkg::REG_DESCENT_RATE: cfg.descent_rate     <= pwdata[15:0];
        lts_pkg::REG_TOTAL_TMO:    cfg.total_timeout    <= pwdata;
        lts_pkg::REG_GROUND_HOLD:  cfg.ground_hold_time <= pwdata;
        lts_pkg::REG_HEIGHT_TOL:   cfg.height_tolerance <= pwdata[22:0];
        lts_pkg::REG_SPEED_TOL:    cfg.speed_tolerance  <= pwdata[14:0];
        lts_pkg::REG_RETRY_PERIOD: cfg.retry_period     <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      lts_pkg::REG_DESCENT_RATE: prdata = {16'd0, cfg.descent_rate};
      lts_pkg::REG_TOTAL_TMO:    prdata = cfg.total_timeout;
      lts_pkg::REG_GROUND_HOLD:  prdata = cfg.ground_hold_time;
      lts_pkg::REG_HEIGHT_TOL:   prdata = {9'd0, cfg.height_tolerance};
      lts_pkg::REG_SPEED_TOL:    prdata = {17'd0, cfg.speed_tolerance};
      lts_pkg::REG_RETRY_PERIOD: prdata = cfg.retry_period;
      default:                   prdata = 32'd0;
    endcase
  end

endmodule

// ===== hw/rtl/lts_step.sv =====
// Sequencer state and the per-request step logic.
module lts_step (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic [1:0]          func,
  input  lts_pkg::in_item_t   item,
  input  lts_pkg::cfg_t       cfg,
  output lts_pkg::out_item_t  result
);

  lts_pkg::phase_t phase, phase_next;
  logic [31:0]     start_stamp, start_stamp_next;
  logic [31:0]     confirm_stamp, confirm_stamp_next;
  logic [31:0]     disarm_stamp, disarm_stamp_next;
  logic            confirming, confirming_next;
  logic [23:0]     home_latched, home_latched_next;

  logic [31:0]        start_el, confirm_el, disarm_el;
  logic signed [24:0] hdiff;
  logic [24:0]        habs;
  logic signed [16:0] vext;
  logic [16:0]        vabs;
  logic               h_ok, v_ok, qual, tmo;

  assign start_el   = item.time_ms - start_stamp;
  assign confirm_el = item.time_ms - confirm_stamp;
  assign disarm_el  = item.time_ms - disarm_stamp;
  assign hdiff      = 25'(item.pos_z) - 25'($signed(home_latched));
  assign habs       = hdiff[24] ? 25'(-hdiff) : 25'(hdiff);
  assign vext       = 17'(item.vert_speed);
  assign vabs       = vext[16] ? 17'(-vext) : 17'(vext);
  assign h_ok       = habs < {2'd0, cfg.height_tolerance};
  assign v_ok       = vabs < {2'd0, cfg.speed_tolerance};
  assign qual       = h_ok && v_ok && item.landed_flag;
  assign tmo        = start_el > cfg.total_timeout;

  always_comb begin
    phase_next         = phase;
    start_stamp_next   = start_stamp;
    confirm_stamp_next = confirm_stamp;
    disarm_stamp_next  = disarm_stamp;
    confirming_next    = confirming;
    home_latched_next  = home_latched;
    result                = '0;
    result.status         = lts_pkg::ST_NONE;
    result.mode_command   = lts_pkg::MODE_NONE;

    case (func)
      lts_pkg::FUNC_START: begin
        if (!item.armed) begin
          result.status = lts_pkg::ST_SUCCESS;
        end else begin
          phase_next        = lts_pkg::PH_INIT;
          start_stamp_next  = item.time_ms;
          confirming_next   = 1'b0;
          home_latched_next = item.home_height;
          result.status     = lts_pkg::ST_RUNNING;
        end
      end
      lts_pkg::FUNC_HALT: begin
        result.mode_command = lts_pkg::MODE_HEARTBEAT;
      end
      lts_pkg::FUNC_TICK: begin
        if (phase != lts_pkg::PH_IDLE) begin
          result.status = lts_pkg::ST_RUNNING;
          if (tmo) begin
            result.mode_command   = lts_pkg::MODE_HEARTBEAT;
            result.disarm_request = 1'b1;
            disarm_stamp_next     = item.time_ms;
            phase_next            = lts_pkg::PH_DISARM;
          end else begin
            case (phase)
              lts_pkg::PH_INIT: begin
                result.target_write = 1'b1;
                result.target_x     = item.pos_x;
                result.target_y     = item.pos_y;
                result.target_vz    = cfg.descent_rate;
                result.mode_command = lts_pkg::MODE_RAW;
                phase_next          = lts_pkg::PH_DESCEND;
              end
              lts_pkg::PH_DESCEND: begin
                if (qual) begin
                  if (!confirming) begin
                    confirming_next    = 1'b1;
                    confirm_stamp_next = item.time_ms;
                  end
                  // A fresh confirmation is not yet tested against the ground hold time.
                  if (confirming && (confirm_el > cfg.ground_hold_time)) begin
                    result.mode_command   = lts_pkg::MODE_HEARTBEAT;
                    result.disarm_request = 1'b1;
                    disarm_stamp_next     = item.time_ms;
                    phase_next            = lts_pkg::PH_DISARM;
                  end
                end else begin
                  confirming_next = 1'b0;
                end
              end
              lts_pkg::PH_DISARM: begin
                if (!item.armed) begin
                  phase_next    = lts_pkg::PH_DONE;
                  result.status = lts_pkg::ST_SUCCESS;
                end else if (disarm_el > cfg.retry_period) begin
                  result.disarm_request = 1'b1;
                  disarm_stamp_next     = item.time_ms;
                end
              end
              lts_pkg::PH_DONE: begin
                result.status = lts_pkg::ST_SUCCESS;
              end
              default: begin
                result.status = lts_pkg::ST_NONE;
              end
            endcase
          end
        end
      end
      default: ;
    endcase

    result.phase_now = phase_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= lts_pkg::PH_IDLE;
      start_stamp   <= '0;
      confirm_stamp <= '0;
      disarm_stamp  <= '0;
      confirming    <= 1'b0;
      home_latched  <= '0;
    end else if (en) begin
      phase         <= phase_next;
      start_stamp   <= start_stamp_next;
      confirm_stamp <= confirm_stamp_next;
      disarm_stamp  <= disarm_stamp_next;
      confirming    <= confirming_next;
      home_latched  <= home_latched_next;
    end
  end

endmodule
